[rtl/pid_pkg.sv]
// ----------------------------------------------------------------------------
// pid_pkg
// Shared widths, register codes and the records passed between the front,
// queue, divider and back end of the PID step block.
// ----------------------------------------------------------------------------
package pid_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned MUL_W       = DATA_W + 1;
   localparam int unsigned PROD_W      = 2 * MUL_W;
   localparam int unsigned DIVD_W      = 2 * DATA_W;
   localparam int unsigned DIV_STEPS   = 2;

   localparam bit WINDUP_CLAMP_ON_DEF = 1'b1;
   localparam bit OUTPUT_CLAMP_ON_DEF = 1'b1;

   localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0]        PERIOD_ONE = DATA_W'(1) << FRAC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN     = 3'd0,
      REG_INTEG_GAIN    = 3'd1,
      REG_DERIV_GAIN    = 3'd2,
      REG_SAMPLE_PERIOD = 3'd3,
      REG_OUTPUT_MIN    = 3'd4,
      REG_OUTPUT_MAX    = 3'd5,
      REG_WINDUP_MIN    = 3'd6,
      REG_WINDUP_MAX    = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic [DATA_W-1:0]        sample_period;
      logic signed [DATA_W-1:0] output_min;
      logic signed [DATA_W-1:0] output_max;
      logic signed [DATA_W-1:0] windup_min;
      logic signed [DATA_W-1:0] windup_max;
   } pid_cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] error;
      logic signed [DATA_W-1:0] half_sum;
      logic signed [DATA_W:0]   error_diff;
   } pid_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic [DIVD_W-1:0] quotient;
   } div_stat_type;

endpackage

[rtl/pid_front.sv]
// ----------------------------------------------------------------------------
// pid_front
// Takes error beats, forms the trapezoid half sum and the error difference
// against the previous sample, and pushes them into the work queue.
// ----------------------------------------------------------------------------
module pid_front
   import pid_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_error_sample,
   input  queue_stat_type           q_stat,
   output logic                     q_push,
   output pid_item_type             q_item
);

   logic signed [DATA_W-1:0] last_error_ff, last_error_in;
   logic signed [DATA_W:0]   sum_w;

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      sum_w = {req_error_sample[DATA_W-1], req_error_sample}
            + {last_error_ff[DATA_W-1], last_error_ff};
      q_item.error      = req_error_sample;
      // floor of half: drop the low bit of the widened sum
      q_item.half_sum   = sum_w[DATA_W:1];
      q_item.error_diff = {req_error_sample[DATA_W-1], req_error_sample}
                        - {last_error_ff[DATA_W-1], last_error_ff};
      last_error_in     = q_push ? req_error_sample : last_error_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
      end else begin
         last_error_ff <= last_error_in;
      end
   end

endmodule

[rtl/pid_queue.sv]
// ----------------------------------------------------------------------------
// pid_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module pid_queue
   import pid_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  pid_item_type   push_item,
   input  logic           pop,
   output pid_item_type   pop_item,
   output queue_stat_type stat
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   pid_item_type     entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_item   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/pid_divider.sv]
// ----------------------------------------------------------------------------
// pid_divider
// Unsigned restoring divider, 64-bit dividend by 32-bit divisor, two
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module pid_divider
   import pid_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output div_stat_type stat
);

   localparam int unsigned ITER  = DIVD_W / DIV_STEPS;
   localparam int unsigned CNT_W = $clog2(ITER);

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   assign stat.busy     = busy_ff;
   assign stat.quotient = quo_ff;

   always_comb begin
      logic [DATA_W:0]   trial;
      logic [DATA_W-1:0] rem_v;
      logic [DIVD_W-1:0] quo_v;
      rem_v      = rem_ff;
      quo_v      = quo_ff;
      trial      = '0;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      if (req.start) begin
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
         cnt_in     = CNT_W'(ITER - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {rem_v, quo_v[DIVD_W-1]};
            quo_v = {quo_v[DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_ff}) begin
               trial    = trial - {1'b0, divisor_ff};
               quo_v[0] = 1'b1;
            end
            rem_v = trial[DATA_W-1:0];
         end
         rem_in = rem_v;
         quo_in = quo_v;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

[rtl/pid_back.sv]
// ----------------------------------------------------------------------------
// pid_back
// Sequencer for one control step: shared multiplier, integral update with
// windup clamp, derivative division, output sum, clamp and result register.
// ----------------------------------------------------------------------------
module pid_back
   import pid_pkg::*;
#(
   parameter bit WINDUP_CLAMP_ON = WINDUP_CLAMP_ON_DEF,
   parameter bit OUTPUT_CLAMP_ON = OUTPUT_CLAMP_ON_DEF
)(
   input  logic                     clock,
   input  logic                     reset,
   input  pid_cfg_type              cfg,
   input  pid_item_type             q_item,
   input  queue_stat_type           q_stat,
   output logic                     q_pop,
   output div_req_type              div_req,
   input  div_stat_type             div_stat,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_drive_value,
   output logic                     rsp_clamped_flag
);

   localparam int unsigned SAT_W = PROD_W - FRAC_W;
   localparam int unsigned P_W   = 2 * DATA_W - FRAC_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_D, ST_DIV_GO, ST_SAT_T, ST_TAKE_P, ST_SAT_INC,
      ST_ACCUM, ST_WAIT_DIV, ST_SAT_D, ST_SUM, ST_CLAMP
   } state_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] value;
   } sat_type;

   function automatic sat_type sat_data(input logic signed [SAT_W-1:0] v);
      sat_type r;
      if (v[SAT_W-1:DATA_W-1] == '0 || v[SAT_W-1:DATA_W-1] == '1) begin
         r.hit   = 1'b0;
         r.value = v[DATA_W-1:0];
      end else begin
         r.hit   = 1'b1;
         r.value = v[SAT_W-1] ? S32_MIN : S32_MAX;
      end
      return r;
   endfunction

   state_type                state_ff, state_in;
   pid_item_type             item_ff, item_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [DATA_W-1:0] t_ff, t_in;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic signed [DATA_W-1:0] inc_ff, inc_in;
   logic signed [DATA_W-1:0] integ_ff, integ_in;
   logic signed [DATA_W-1:0] d_ff, d_in;
   logic                     d_neg_ff, d_neg_in;
   logic signed [DATA_W-1:0] y_ff, y_in;
   logic                     flag_ff, flag_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                     rsp_flag_ff, rsp_flag_in;

   logic signed [DATA_W-1:0] wmin, wmax, omin, omax;
   logic [DATA_W-1:0]        period;

   assign wmin   = cfg.windup_min;
   assign wmax   = cfg.windup_max;
   assign omin   = cfg.output_min;
   assign omax   = cfg.output_max;
   assign period = cfg.sample_period;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_value  = rsp_drive_ff;
   assign rsp_clamped_flag = rsp_flag_ff;

   always_comb begin
      sat_type                  s;
      logic signed [PROD_W-1:0] mag;
      logic [DIVD_W-1:0]        quo;
      logic signed [DATA_W:0]   acc;
      logic signed [DATA_W-1:0] v;
      logic signed [SAT_W-1:0]  ysum;
      s            = '0;
      mag          = '0;
      quo          = div_stat.quotient;
      acc          = '0;
      v            = '0;
      ysum         = '0;
      state_in     = state_ff;
      item_in      = item_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      inc_in       = inc_ff;
      integ_in     = integ_ff;
      d_in         = d_ff;
      d_neg_in     = d_neg_ff;
      y_in         = y_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drive_in = rsp_drive_ff;
      rsp_flag_in  = rsp_flag_ff;
      q_pop        = 1'b0;
      div_req      = '0;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               flag_in  = 1'b0;
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            mul_a    = item_ff.error_diff;
            mul_b    = {cfg.deriv_gain[DATA_W-1], cfg.deriv_gain};
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            // divide magnitudes, put the sign back afterwards (truncate to zero)
            d_neg_in         = prod_ff[PROD_W-1];
            mag              = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
            div_req.start    = 1'b1;
            div_req.dividend = mag[DIVD_W-1:0];
            div_req.divisor  = (period == '0) ? DATA_W'(1) : period;
            mul_a            = {item_ff.half_sum[DATA_W-1], item_ff.half_sum};
            mul_b            = {cfg.integ_gain[DATA_W-1], cfg.integ_gain};
            state_in         = ST_SAT_T;
         end
         ST_SAT_T: begin
            s        = sat_data(prod_ff[PROD_W-1:FRAC_W]);
            t_in     = s.value;
            flag_in  = flag_ff | s.hit;
            mul_a    = {item_ff.error[DATA_W-1], item_ff.error};
            mul_b    = {cfg.prop_gain[DATA_W-1], cfg.prop_gain};
            state_in = ST_TAKE_P;
         end
         ST_TAKE_P: begin
            p_in     = prod_ff[2*DATA_W-1:FRAC_W];
            mul_a    = {t_ff[DATA_W-1], t_ff};
            mul_b    = {1'b0, period};
            state_in = ST_SAT_INC;
         end
         ST_SAT_INC: begin
            s        = sat_data(prod_ff[PROD_W-1:FRAC_W]);
            inc_in   = s.value;
            flag_in  = flag_ff | s.hit;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            acc     = {integ_ff[DATA_W-1], integ_ff} + {inc_ff[DATA_W-1], inc_ff};
            s       = sat_data({{(SAT_W-DATA_W-1){acc[DATA_W]}}, acc});
            flag_in = flag_ff | s.hit;
            v       = s.value;
            if (WINDUP_CLAMP_ON) begin
               // raise to min first, then lower to max: max wins when crossed
               if (v < wmin) begin
                  v = wmin;
               end
               if (v > wmax) begin
                  v = wmax;
               end
            end
            integ_in = v;
            state_in = ST_WAIT_DIV;
         end
         ST_WAIT_DIV: begin
            if (!div_stat.busy) begin
               state_in = ST_SAT_D;
            end
         end
         ST_SAT_D: begin
            if (!d_neg_ff) begin
               if (quo[DIVD_W-1:DATA_W-1] != '0) begin
                  d_in    = S32_MAX;
                  flag_in = 1'b1;
               end else begin
                  d_in = quo[DATA_W-1:0];
               end
            end else begin
               if (quo[DIVD_W-1:DATA_W] != '0
                   || (quo[DATA_W-1] && quo[DATA_W-2:0] != '0)) begin
                  d_in    = S32_MIN;
                  flag_in = 1'b1;
               end else begin
                  d_in = -quo[DATA_W-1:0];
               end
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            ysum = {{(SAT_W-P_W){p_ff[P_W-1]}}, p_ff}
                 + {{(SAT_W-DATA_W){integ_ff[DATA_W-1]}}, integ_ff}
                 + {{(SAT_W-DATA_W){d_ff[DATA_W-1]}}, d_ff};
            s        = sat_data(ysum);
            y_in     = s.value;
            flag_in  = flag_ff | s.hit;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            v = y_ff;
            if (OUTPUT_CLAMP_ON) begin
               if (v < omin) begin
                  v = omin;
               end
               if (v > omax) begin
                  v = omax;
               end
            end
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = v;
               rsp_flag_in  = flag_ff | (v != y_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      prod_ff      <= prod_in;
      t_ff         <= t_in;
      p_ff         <= p_in;
      inc_ff       <= inc_in;
      d_ff         <= d_in;
      d_neg_ff     <= d_neg_in;
      y_ff         <= y_in;
      flag_ff      <= flag_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule

[rtl/pid_controller_step.sv]
// ----------------------------------------------------------------------------
// pid_controller_step
// PID control step in signed Q16.16: trapezoidal integral, optional windup clamp,
// derivative divided by the sample period, saturated output, optional clamp.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_error_sample
//   rsp      out        rsp_valid / rsp_ready   rsp_drive_value, rsp_clamped_flag
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// An item leaves the queue and passes the shared multiplier and saturation
// steps while the divider, two quotient bits a cycle over a 64-bit dividend,
// runs alongside; the divider sets most of its time to a result.
// The front takes two further beats into its queue while the back is busy.
// Reset is synchronous: gains to zero, period to one, limits fully open,
// integral and previous error to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_controller_step
   import pid_pkg::*;
#(
   parameter bit WINDUP_CLAMP_ON = WINDUP_CLAMP_ON_DEF,
   parameter bit OUTPUT_CLAMP_ON = OUTPUT_CLAMP_ON_DEF
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_error_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_drive_value,
   output logic                     rsp_clamped_flag,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   pid_cfg_type    cfg_ff, cfg_in;
   queue_stat_type q_stat;
   pid_item_type   push_item, pop_item;
   logic           q_push, q_pop;
   div_req_type    div_req;
   div_stat_type   div_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PROP_GAIN:     cfg_in.prop_gain     = csr_data;
            REG_INTEG_GAIN:    cfg_in.integ_gain    = csr_data;
            REG_DERIV_GAIN:    cfg_in.deriv_gain    = csr_data;
            REG_SAMPLE_PERIOD: cfg_in.sample_period = csr_data;
            REG_OUTPUT_MIN:    cfg_in.output_min    = csr_data;
            REG_OUTPUT_MAX:    cfg_in.output_max    = csr_data;
            REG_WINDUP_MIN:    cfg_in.windup_min    = csr_data;
            REG_WINDUP_MAX:    cfg_in.windup_max    = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= '0;
         cfg_ff.integ_gain    <= '0;
         cfg_ff.deriv_gain    <= '0;
         cfg_ff.sample_period <= PERIOD_ONE;
         cfg_ff.output_min    <= S32_MIN;
         cfg_ff.output_max    <= S32_MAX;
         cfg_ff.windup_min    <= S32_MIN;
         cfg_ff.windup_max    <= S32_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pid_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_error_sample (req_error_sample),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   pid_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   pid_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   pid_back #(
      .WINDUP_CLAMP_ON (WINDUP_CLAMP_ON),
      .OUTPUT_CLAMP_ON (OUTPUT_CLAMP_ON)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_item           (pop_item),
      .q_stat           (q_stat),
      .q_pop            (q_pop),
      .div_req          (div_req),
      .div_stat         (div_stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive_value  (rsp_drive_value),
      .rsp_clamped_flag (rsp_clamped_flag)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue pushed while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_stat.busy)
      else $error("divider started while busy");

endmodule
